// ===== rtl/bea_pkg.sv =====
// ----------------------------------------------------------------------------
// bea_pkg
// Shared constants for the bitmap extent allocator core.
// ----------------------------------------------------------------------------
package bea_pkg;

	localparam int MAX_BLOCKS_DEF  = 4096;
	localparam int MAX_EXTENTS_DEF = 29;

	localparam int CNT_W   = 13;
	localparam int BLK_W   = 12;
	localparam int STAT_W  = 2;
	localparam int CFG_W   = 13;
	localparam int CFGA_W  = 1;

	localparam logic [CFGA_W-1:0] REG_TOTAL_BLOCKS = 1'd0;
	localparam logic [CFGA_W-1:0] REG_FIRST_DATA   = 1'd1;

	localparam logic [CNT_W-1:0] TOTAL_RST = 13'd4096;
	localparam logic [BLK_W-1:0] FIRST_RST = 12'd0;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAILED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

endpackage

// ===== rtl/bitmap_extent_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_extent_allocator_core
// First-fit extent allocator over a one-bit-per-block used map.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the kind (allocate or release), tdata
//   holds block_count, min_chunk and start_block. m_axis carries results:
//   tuser is the status, tdata the extent start and length, tlast marks the
//   final result of a request. cfg_we/cfg_addr/cfg_wdata write total_blocks
//   and first_data_block; the user must write them only while the core is
//   idle; the core does not enforce it. The used map is a bit memory with
//   one write and one read port. An allocate scans it one bit at a time
//   from first_data_block, rescanning for each extent found, marks one
//   block per cycle in S_MARK and sends each extent through S_EM_RD and
//   S_EM_OUT; a failed allocate rolls back one marked block per cycle in
//   S_RB_CLR. A release clears one block per cycle in S_REL. Latency
//   therefore depends on map occupancy: an ignored or empty request goes
//   from S_IDLE straight to S_RES. After reset the core sweeps the map
//   clear in S_CLR and takes no request meanwhile. One request is worked
//   on at a time; a result waits in the output register while m_axis_tready
//   is low, and the core stalls only when it must present another result.
// ----------------------------------------------------------------------------
module bitmap_extent_allocator_core #(
	parameter int MAX_BLOCKS  = bea_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_EXTENTS = bea_pkg::MAX_EXTENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [39:0]                 s_axis_tdata,  // block_count, min_chunk, start_block, pad
	input  logic                        s_axis_tuser,  // kind
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // extent_start, extent_length, pad
	output logic [bea_pkg::STAT_W-1:0]  m_axis_tuser,  // status
	output logic                        m_axis_tlast,
	input  logic                        cfg_we,
	input  logic [bea_pkg::CFGA_W-1:0]  cfg_addr,
	input  logic [bea_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int NW = $clog2(MAX_EXTENTS + 1);

	typedef enum logic [10:0] {
		S_CLR    = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_RD     = 11'b00000000100,
		S_CK     = 11'b00000001000,
		S_MARK   = 11'b00000010000,
		S_RB_RD  = 11'b00000100000,
		S_RB_CLR = 11'b00001000000,
		S_EM_RD  = 11'b00010000000,
		S_EM_OUT = 11'b00100000000,
		S_RES    = 11'b01000000000,
		S_REL    = 11'b10000000000
	} state_t;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [CW-1:0] len;
	} ext_t;

	state_t state_q;
	logic [bea_pkg::CNT_W-1:0] total_q;
	logic [bea_pkg::BLK_W-1:0] first_q;
	logic [CW-1:0] cur_q, run_len_q, k_q, end_q;
	logic [AW-1:0] run_start_q;
	logic in_run_q;
	logic [bea_pkg::CNT_W-1:0] rem_q, chunk_q;
	logic [NW-1:0] n_q, e_q;
	logic [bea_pkg::STAT_W-1:0] res_status_q;
	logic o_valid_q, o_last_q;
	logic [bea_pkg::STAT_W-1:0] o_status_q;
	logic [bea_pkg::BLK_W-1:0] o_start_q;
	logic [bea_pkg::CNT_W-1:0] o_len_q;

	logic map_q [MAX_BLOCKS];
	ext_t ext_q [MAX_EXTENTS];
	logic rd_bit_q;
	ext_t ext_rd_q;

	logic mem_we, mem_wd;
	logic [AW-1:0] mem_wa;
	logic ext_we;

	logic [CW-1:0] eff;
	logic [CW-1:0] nxt;
	logic [CW-1:0] len_new;
	logic [AW-1:0] start_new;
	logic out_free;
	logic o_load;
	logic accept;
	logic [bea_pkg::CNT_W-1:0] in_count, in_chunk;
	logic [bea_pkg::BLK_W-1:0] in_start;
	logic [31:0] rel_end;

	assign in_count = s_axis_tdata[12:0];
	assign in_chunk = s_axis_tdata[25:13];
	assign in_start = s_axis_tdata[37:26];

	assign eff = (32'(total_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(total_q);
	assign nxt = cur_q + CW'(1);
	assign len_new = !in_run_q ? CW'(1) : (rd_bit_q ? run_len_q : run_len_q + CW'(1));
	assign start_new = in_run_q ? run_start_q : cur_q[AW-1:0];
	assign out_free = !o_valid_q || m_axis_tready;
	assign o_load = out_free && (state_q == S_EM_OUT || state_q == S_RES);
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign rel_end = (32'(in_start) + 32'(in_count) > 32'(eff)) ? 32'(eff)
		: 32'(in_start) + 32'(in_count);

	always_comb begin
		mem_we = 1'b0;
		mem_wd = 1'b0;
		mem_wa = cur_q[AW-1:0];
		ext_we = 1'b0;
		unique case (state_q)
			S_CLR, S_REL: begin
				mem_we = 1'b1;
			end
			S_MARK: begin
				mem_we = 1'b1;
				mem_wd = 1'b1;
				mem_wa = run_start_q + AW'(k_q);
				ext_we = (k_q == run_len_q - CW'(1));
			end
			S_RB_CLR: begin
				mem_we = 1'b1;
				mem_wa = ext_rd_q.start + AW'(k_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_q[mem_wa] <= mem_wd;
		end
		rd_bit_q <= map_q[cur_q[AW-1:0]];
		if (ext_we) begin
			ext_q[n_q[EW-1:0]] <= '{start: run_start_q, len: run_len_q};
		end
		ext_rd_q <= ext_q[e_q[EW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bea_pkg::TOTAL_RST;
			first_q <= bea_pkg::FIRST_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bea_pkg::REG_TOTAL_BLOCKS: total_q <= cfg_wdata;
				bea_pkg::REG_FIRST_DATA:   first_q <= cfg_wdata[bea_pkg::BLK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (o_load) begin
			o_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cur_q        <= '0;
			run_len_q    <= '0;
			run_start_q  <= '0;
			in_run_q     <= 1'b0;
			k_q          <= '0;
			end_q        <= '0;
			rem_q        <= '0;
			chunk_q      <= '0;
			n_q          <= '0;
			e_q          <= '0;
			res_status_q <= bea_pkg::ST_DONE;
			o_last_q     <= 1'b0;
			o_status_q   <= bea_pkg::ST_DONE;
			o_start_q    <= '0;
			o_len_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cur_q <= nxt;
					if (32'(cur_q) == 32'(MAX_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == bea_pkg::KIND_RELEASE) begin
							cur_q <= CW'(in_start);
							end_q <= CW'(rel_end);
							if (32'(in_start) >= 32'(eff)) begin
								res_status_q <= bea_pkg::ST_IGNORED;
								state_q      <= S_RES;
							end else if (32'(in_start) < rel_end) begin
								res_status_q <= bea_pkg::ST_DONE;
								state_q      <= S_REL;
							end else begin
								res_status_q <= bea_pkg::ST_DONE;
								state_q      <= S_RES;
							end
						end else begin
							chunk_q  <= (in_chunk < in_count) ? in_chunk : in_count;
							rem_q    <= in_count;
							n_q      <= '0;
							in_run_q <= 1'b0;
							cur_q    <= CW'(first_q);
							if (in_count == '0 || 32'(first_q) >= 32'(eff)) begin
								res_status_q <= bea_pkg::ST_FAILED;
								state_q      <= S_RES;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_CK;
				end
				S_CK: begin
					if (!in_run_q && rd_bit_q) begin
						if (nxt >= eff) begin
							res_status_q <= bea_pkg::ST_FAILED;
							e_q          <= '0;
							k_q          <= '0;
							state_q      <= (n_q == '0) ? S_RES : S_RB_RD;
						end else begin
							cur_q   <= nxt;
							state_q <= S_RD;
						end
					end else if (!rd_bit_q && 32'(len_new) < 32'(rem_q) && nxt < eff) begin
						in_run_q    <= 1'b1;
						run_len_q   <= len_new;
						run_start_q <= start_new;
						cur_q       <= nxt;
						state_q     <= S_RD;
					end else if (32'(len_new) >= 32'(chunk_q)) begin
						if (32'(n_q) == 32'(MAX_EXTENTS)) begin
							res_status_q <= bea_pkg::ST_FAILED;
							e_q          <= '0;
							k_q          <= '0;
							state_q      <= S_RB_RD;
						end else begin
							run_len_q   <= len_new;
							run_start_q <= start_new;
							in_run_q    <= 1'b0;
							k_q         <= '0;
							state_q     <= S_MARK;
						end
					end else begin
						in_run_q <= 1'b0;
						if (rd_bit_q) begin
							state_q <= S_RD;
						end else if (nxt < eff) begin
							cur_q   <= nxt;
							state_q <= S_RD;
						end else begin
							res_status_q <= bea_pkg::ST_FAILED;
							e_q          <= '0;
							k_q          <= '0;
							state_q      <= (n_q == '0) ? S_RES : S_RB_RD;
						end
					end
				end
				S_MARK: begin
					k_q <= k_q + CW'(1);
					if (k_q == run_len_q - CW'(1)) begin
						n_q   <= n_q + NW'(1);
						rem_q <= rem_q - bea_pkg::CNT_W'(run_len_q);
						cur_q <= CW'(first_q);
						e_q   <= '0;
						if (32'(rem_q) == 32'(run_len_q)) begin
							state_q <= S_EM_RD;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RB_RD: begin
					k_q     <= '0;
					state_q <= S_RB_CLR;
				end
				S_RB_CLR: begin
					k_q <= k_q + CW'(1);
					if (k_q == ext_rd_q.len - CW'(1)) begin
						if (e_q + NW'(1) == n_q) begin
							state_q <= S_RES;
						end else begin
							e_q     <= e_q + NW'(1);
							state_q <= S_RB_RD;
						end
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (out_free) begin
						o_status_q <= bea_pkg::ST_DONE;
						o_start_q  <= bea_pkg::BLK_W'(ext_rd_q.start);
						o_len_q    <= bea_pkg::CNT_W'(ext_rd_q.len);
						o_last_q   <= (e_q + NW'(1) == n_q);
						if (e_q + NW'(1) == n_q) begin
							state_q <= S_IDLE;
						end else begin
							e_q     <= e_q + NW'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						o_status_q <= res_status_q;
						o_start_q  <= '0;
						o_len_q    <= '0;
						o_last_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_REL: begin
					cur_q <= nxt;
					if (nxt >= end_q) begin
						state_q <= S_RES;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tuser  = o_status_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {7'd0, o_len_q, o_start_q};

`ifndef SYNTHESIS
	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) <= 32'(MAX_EXTENTS))
		else $error("extent count past list size");
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> 32'(run_start_q) + 32'(k_q) < 32'(eff))
		else $error("marking past volume end");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> $onehot(state_q) && state_q == S_IDLE)
		else $error("ready outside idle");
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EM_OUT && out_free |=> o_valid_q && o_status_q == bea_pkg::ST_DONE)
		else $error("extent result not loaded");
`endif

endmodule

// ===== tb/bitmap_extent_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// bitmap_extent_allocator_checker
// Watches request, result and register-write traffic of the allocator core,
// keeps its own copy of the used map, predicts the result transactions of
// every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module bitmap_extent_allocator_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [39:0]                 s_axis_tdata,
	input  logic                        s_axis_tuser,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [31:0]                 m_axis_tdata,
	input  logic [bea_pkg::STAT_W-1:0]  m_axis_tuser,
	input  logic                        m_axis_tlast,
	input  logic                        cfg_we,
	input  logic [bea_pkg::CFGA_W-1:0]  cfg_addr,
	input  logic [bea_pkg::CFG_W-1:0]   cfg_wdata,
	output int                          fail_count,
	output int                          pending
);

	typedef struct packed {
		logic [bea_pkg::STAT_W-1:0] status;
		logic [bea_pkg::BLK_W-1:0]  ext_start;
		logic [bea_pkg::CNT_W-1:0]  ext_len;
		logic                       last;
	} extent_rsp_t;

	bit          used_bits [bea_pkg::MAX_BLOCKS_DEF];
	int          volume_blocks;
	int          scan_base;
	extent_rsp_t rsp_queue [$];

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	function automatic int usable_blocks();
		return volume_blocks < bea_pkg::MAX_BLOCKS_DEF ? volume_blocks
			: bea_pkg::MAX_BLOCKS_DEF;
	endfunction

	task automatic predict_allocate(input int count, input int min_chunk);
		int total, chunk, remaining, n, i, run_start, run_len;
		int ext_s [bea_pkg::MAX_EXTENTS_DEF];
		int ext_l [bea_pkg::MAX_EXTENTS_DEF];
		bit failed, found;
		total = usable_blocks();
		chunk = min_chunk < count ? min_chunk : count;
		remaining = count;
		n = 0;
		failed = (count == 0);
		while (!failed && remaining > 0) begin
			found = 0;
			for (i = scan_base; i < total; i++) begin
				if (used_bits[i])
					continue;
				run_start = i;
				run_len = 1;
				while (run_len < remaining && i + 1 < total && !used_bits[i + 1]) begin
					i++;
					run_len++;
				end
				if (run_len >= chunk) begin
					if (n >= bea_pkg::MAX_EXTENTS_DEF) begin
						failed = 1;
						break;
					end
					for (int b = 0; b < run_len; b++)
						used_bits[run_start + b] = 1;
					ext_s[n] = run_start;
					ext_l[n] = run_len;
					n++;
					remaining -= run_len;
					found = 1;
					break;
				end
			end
			if (!found)
				failed = 1;
		end
		if (failed) begin
			for (int e = 0; e < n; e++)
				for (int b = 0; b < ext_l[e]; b++)
					used_bits[ext_s[e] + b] = 0;
			rsp_queue.push_back('{bea_pkg::ST_FAILED, '0, '0, 1'b1});
		end else begin
			for (int e = 0; e < n; e++)
				rsp_queue.push_back('{bea_pkg::ST_DONE, bea_pkg::BLK_W'(ext_s[e]),
					bea_pkg::CNT_W'(ext_l[e]), e == n - 1});
		end
	endtask

	task automatic predict_release(input int start, input int count);
		int total, stop;
		total = usable_blocks();
		if (start >= total) begin
			rsp_queue.push_back('{bea_pkg::ST_IGNORED, '0, '0, 1'b1});
		end else begin
			stop = start + count > total ? total : start + count;
			for (int i = start; i < stop; i++)
				used_bits[i] = 0;
			rsp_queue.push_back('{bea_pkg::ST_DONE, '0, '0, 1'b1});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		extent_rsp_t want;
		if (!arst_n) begin
			foreach (used_bits[i])
				used_bits[i] = 0;
			volume_blocks = bea_pkg::TOTAL_RST;
			scan_base = bea_pkg::FIRST_RST;
			rsp_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == bea_pkg::REG_TOTAL_BLOCKS)
					volume_blocks = cfg_wdata;
				else if (cfg_addr == bea_pkg::REG_FIRST_DATA)
					scan_base = cfg_wdata[bea_pkg::BLK_W-1:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (rsp_queue.size() == 0) begin
					report("unexpected result transaction", m_axis_tuser, -1);
				end else begin
					want = rsp_queue.pop_front();
					if (m_axis_tuser != want.status)
						report("status", m_axis_tuser, want.status);
					if (m_axis_tdata[11:0] != want.ext_start)
						report("extent_start", m_axis_tdata[11:0], want.ext_start);
					if (m_axis_tdata[24:12] != want.ext_len)
						report("extent_length", m_axis_tdata[24:12], want.ext_len);
					if (m_axis_tlast != want.last)
						report("last", m_axis_tlast, want.last);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == bea_pkg::KIND_ALLOC)
					predict_allocate(s_axis_tdata[12:0], s_axis_tdata[25:13]);
				else
					predict_release(s_axis_tdata[37:26], s_axis_tdata[12:0]);
			end
		end
		pending = rsp_queue.size();
	end

endmodule

// ===== tb/bitmap_extent_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_extent_allocator_core_tb
// Drives allocate and release requests through several volume settings,
// directed corner cases first and random traffic after, with bursty input,
// stalling output and long hold-offs; the checker compares every result.
// ----------------------------------------------------------------------------
module bitmap_extent_allocator_core_tb;

	localparam int IDLE_LIMIT = 400000;

	logic                        clk;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [39:0]                 s_axis_tdata;
	logic                        s_axis_tuser;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready;
	logic [31:0]                 m_axis_tdata;
	logic [bea_pkg::STAT_W-1:0]  m_axis_tuser;
	logic                        m_axis_tlast;
	logic                        cfg_we;
	logic [bea_pkg::CFGA_W-1:0]  cfg_addr;
	logic [bea_pkg::CFG_W-1:0]   cfg_wdata;
	int                          fail_count;
	int                          pending;
	int                          idle_cycles;
	bit                          hold_off;

	bitmap_extent_allocator_core dut (.*);

	bitmap_extent_allocator_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 0;
		else
			case ($urandom_range(3))
				0:       m_axis_tready <= 0;
				1:       m_axis_tready <= $urandom_range(1);
				default: m_axis_tready <= 1;
			endcase
	end

	task automatic send_request(input logic kind, input int count, input int min_chunk,
		input int start);
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b0, bea_pkg::BLK_W'(start), bea_pkg::CNT_W'(min_chunk),
			bea_pkg::CNT_W'(count)};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bea_pkg::CFGA_W-1:0] idx, input int value);
		cfg_we    <= 1;
		cfg_addr  <= idx;
		cfg_wdata <= bea_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_traffic(input int items);
		int burst;
		while (items > 0) begin
			burst = $urandom_range(8, 1);
			while (burst > 0 && items > 0) begin
				case ($urandom_range(9))
					0: send_request(bea_pkg::KIND_ALLOC, $urandom_range(8191),
						$urandom_range(8191), $urandom_range(4095));
					1, 2, 3: send_request(bea_pkg::KIND_RELEASE, $urandom_range(64),
						$urandom_range(8191), $urandom_range(300));
					4: send_request(bea_pkg::KIND_RELEASE, $urandom_range(8191),
						$urandom_range(8191), $urandom_range(4095));
					default: send_request(bea_pkg::KIND_ALLOC, $urandom_range(40, 1),
						$urandom_range(6), $urandom_range(4095));
				endcase
				burst--;
				items--;
			end
			if ($urandom_range(1)) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(20)) @(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = bea_pkg::KIND_ALLOC;
		cfg_we = 0;
		cfg_addr = bea_pkg::REG_TOTAL_BLOCKS;
		cfg_wdata = '0;
		hold_off = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;

		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 256);
		write_reg(bea_pkg::REG_FIRST_DATA, 4);
		send_request(bea_pkg::KIND_ALLOC, 0, 3, 0);
		send_request(bea_pkg::KIND_ALLOC, 10, 0, 0);
		send_request(bea_pkg::KIND_ALLOC, 1, 1, 0);
		for (int i = 0; i < 10; i++)
			send_request(bea_pkg::KIND_RELEASE, 1, 0, 20 + 2 * i);
		send_request(bea_pkg::KIND_ALLOC, 40, 1, 0);
		send_request(bea_pkg::KIND_ALLOC, 500, 500, 0);
		send_request(bea_pkg::KIND_RELEASE, 8191, 8191, 4095);
		send_request(bea_pkg::KIND_RELEASE, 4, 0, 254);
		send_request(bea_pkg::KIND_ALLOC, 8191, 8191, 0);
		send_request(bea_pkg::KIND_RELEASE, 300, 0, 0);
		send_request(bea_pkg::KIND_ALLOC, 252, 252, 0);
		send_request(bea_pkg::KIND_RELEASE, 4096, 0, 0);
		drain();

		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 64);
		write_reg(bea_pkg::REG_FIRST_DATA, 4095);
		send_request(bea_pkg::KIND_ALLOC, 1, 1, 0);
		send_request(bea_pkg::KIND_RELEASE, 1, 1, 63);
		drain();
		write_reg(bea_pkg::REG_FIRST_DATA, 0);
		for (int i = 0; i < 30; i++)
			send_request(bea_pkg::KIND_ALLOC, 1, 1, 0);
		for (int i = 0; i < 30; i++)
			send_request(bea_pkg::KIND_RELEASE, 1, 0, 2 * i);
		send_request(bea_pkg::KIND_ALLOC, 30, 1, 0);
		send_request(bea_pkg::KIND_ALLOC, 29, 1, 0);
		drain();

		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 8191);
		write_reg(bea_pkg::REG_FIRST_DATA, 0);
		send_request(bea_pkg::KIND_ALLOC, 4096, 4096, 0);
		send_request(bea_pkg::KIND_RELEASE, 4096, 0, 0);
		drain();

		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 1);
		send_request(bea_pkg::KIND_ALLOC, 1, 8191, 0);
		send_request(bea_pkg::KIND_RELEASE, 1, 0, 1);
		send_request(bea_pkg::KIND_RELEASE, 1, 0, 0);
		drain();

		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 300);
		write_reg(bea_pkg::REG_FIRST_DATA, 16);
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			random_traffic(30);
		join
		drain();

		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 4096);
		write_reg(bea_pkg::REG_FIRST_DATA, 0);
		send_request(bea_pkg::KIND_RELEASE, 4096, 0, 0);
		drain();
		write_reg(bea_pkg::REG_TOTAL_BLOCKS, 200);
		random_traffic(30);
		drain();

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bea_pkg.sv
rtl/bitmap_extent_allocator_core.sv
tb/bitmap_extent_allocator_checker.sv
tb/bitmap_extent_allocator_core_tb.sv
